### src/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared constants for the text console writer
// screen geometry, field widths, command and register codes
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 4;
    localparam int CELL_W  = 16;
    localparam int LIN_W   = ROW_W + COL_W;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int PTR_W   = $clog2(CELLS + 1);

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic REG_BACKGROUND = 1'b0;
    localparam logic REG_FOREGROUND = 1'b1;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'hF;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

endpackage

### src/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console engine
// character cell buffer with cursor, line wrap and scroll
// ----------------------------------------------------------------------------
// After reset the block sweeps the cell buffer to zero, one cell per cycle,
// and takes no beat before the sweep is done. A put is written in the cycle
// it is taken and its result is registered for the next cycle; a read goes
// through the registered ram port and the ST_READ state before its result
// is registered. A put that runs past the last row starts a scroll: the
// single ram read/write port pair moves one cell per cycle up a row, taking
// the current colors, then the bottom row is cleared, and only then is the
// put's result given. The next beat is taken only once the block is back
// in idle and the result register is free or being drained.
module text_console_writer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [tcw_pkg::COLOR_W-1:0]  cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_cmd,
    input  logic [tcw_pkg::CHAR_W-1:0]   s_char_code,
    input  logic [tcw_pkg::ROW_W-1:0]    s_read_row,
    input  logic [tcw_pkg::COL_W-1:0]    s_read_col,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tcw_pkg::CELL_W-1:0]   m_cell_data,
    output logic [tcw_pkg::ROW_W-1:0]    m_cursor_row,
    output logic [tcw_pkg::COL_W-1:0]    m_cursor_col
);
    import tcw_pkg::*;

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_READ   = 2'd2;
    localparam logic [1:0] ST_SCROLL = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic               pend_reg, pend_next;
    logic               rd_ok_reg, rd_ok_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ADDR_W-1:0]  cur_reg, cur_next;
    logic [COLOR_W-1:0] bg_reg, bg_next;
    logic [COLOR_W-1:0] fg_reg, fg_next;
    logic               m_valid_reg, m_valid_next;
    logic [CELL_W-1:0]  cell_reg, cell_next;
    logic [ROW_W-1:0]   orow_reg, orow_next;
    logic [COL_W-1:0]   ocol_reg, ocol_next;

    logic               accept;
    logic [LIN_W-1:0]   rd_lin;
    logic               rd_in_range;
    logic [PTR_W-1:0]   scroll_waddr;
    logic [CHAR_W-1:0]  attr;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [CELL_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [CELL_W-1:0]  ram_rdata;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready      = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept       = s_valid && s_ready;
    assign attr         = {bg_reg, fg_reg};
    assign rd_lin       = LIN_W'(s_read_row) * LIN_W'(COLUMNS) + LIN_W'(s_read_col);
    assign rd_in_range  = (LIN_W'(s_read_row) < LIN_W'(ROWS))
                       && (LIN_W'(s_read_col) < LIN_W'(COLUMNS));
    assign scroll_waddr = ptr_reg - PTR_W'(COLUMNS + 1);

    assign m_valid      = m_valid_reg;
    assign m_cell_data  = cell_reg;
    assign m_cursor_row = orow_reg;
    assign m_cursor_col = ocol_reg;

    // ram port steering
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cur_reg;
        ram_wdata = '0;
        ram_raddr = rd_lin[ADDR_W-1:0];
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg[ADDR_W-1:0];
            end
            ST_IDLE: begin
                ram_we    = accept && (s_cmd == CMD_PUT);
                ram_wdata = {attr, s_char_code};
            end
            ST_READ: begin
                ram_we = 1'b0;
            end
            ST_SCROLL: begin
                ram_raddr = ptr_reg[ADDR_W-1:0];
                ram_we    = ptr_reg > PTR_W'(COLUMNS);
                ram_waddr = scroll_waddr[ADDR_W-1:0];
                ram_wdata = {attr, ram_rdata[CHAR_W-1:0]};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        pend_next    = pend_reg;
        rd_ok_next   = rd_ok_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        cur_next     = cur_reg;
        bg_next      = bg_reg;
        fg_next      = fg_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cell_next    = cell_reg;
        orow_next    = orow_reg;
        ocol_next    = ocol_reg;

        if (cfg_we) begin
            unique case (cfg_index)
                REG_BACKGROUND: bg_next = cfg_data;
                REG_FOREGROUND: fg_next = cfg_data;
                default:        bg_next = bg_reg;
            endcase
        end

        unique case (state_reg)
            ST_CLEAR: begin
                ptr_next = PTR_W'(ptr_reg + 1'b1);
                if (ptr_reg == PTR_W'(CELLS - 1)) begin
                    state_next = ST_IDLE;
                    if (pend_reg) begin
                        pend_next    = 1'b0;
                        m_valid_next = 1'b1;
                        cell_next    = '0;
                        orow_next    = row_reg;
                        ocol_next    = col_reg;
                    end
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_cmd == CMD_PUT) begin
                        cur_next = ADDR_W'(cur_reg + 1'b1);
                        col_next = COL_W'(col_reg + 1'b1);
                        if (col_reg == COL_W'(COLUMNS - 1)) begin
                            col_next = '0;
                            if (row_reg == ROW_W'(ROWS - 1)) begin
                                cur_next   = ADDR_W'(CELLS - COLUMNS);
                                ptr_next   = PTR_W'(COLUMNS);
                                pend_next  = 1'b1;
                                state_next = ST_SCROLL;
                            end else begin
                                row_next = ROW_W'(row_reg + 1'b1);
                            end
                        end
                        if (state_next == ST_IDLE) begin
                            m_valid_next = 1'b1;
                            cell_next    = '0;
                            orow_next    = row_next;
                            ocol_next    = col_next;
                        end
                    end else begin
                        rd_ok_next = rd_in_range;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                m_valid_next = 1'b1;
                cell_next    = rd_ok_reg ? ram_rdata : '0;
                orow_next    = row_reg;
                ocol_next    = col_reg;
                state_next   = ST_IDLE;
            end
            ST_SCROLL: begin
                ptr_next = PTR_W'(ptr_reg + 1'b1);
                if (ptr_reg == PTR_W'(CELLS)) begin
                    ptr_next   = PTR_W'(CELLS - COLUMNS);
                    state_next = ST_CLEAR;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            ptr_reg     <= '0;
            pend_reg    <= 1'b0;
            row_reg     <= '0;
            col_reg     <= '0;
            cur_reg     <= '0;
            bg_reg      <= BG_RESET;
            fg_reg      <= FG_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            pend_reg    <= pend_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            cur_reg     <= cur_next;
            bg_reg      <= bg_next;
            fg_reg      <= fg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_ok_reg <= rd_ok_next;
        cell_reg  <= cell_next;
        orow_reg  <= orow_next;
        ocol_reg  <= ocol_next;
    end

    // cursor stays on screen
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_reg < COL_W'(COLUMNS)) && (row_reg < ROW_W'(ROWS)))
        else $error("cursor off screen");

    // during a scroll the cursor sits at the start of the bottom row
    a_scroll_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCROLL) |->
            (row_reg == ROW_W'(ROWS - 1)) && (col_reg == '0)
            && (cur_reg == ADDR_W'(CELLS - COLUMNS)))
        else $error("cursor wrong during scroll");

    // a beat is never taken while an undrained result is held
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> (!m_valid_reg || m_ready))
        else $error("input beat taken over held result");

    // a read beat yields its result after the ram read register and the ST_READ state
    a_read_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_cmd == CMD_READ)) |=> ##1 m_valid_reg)
        else $error("read result missing");

endmodule

### src/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram: generic single-clock ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### tb/tb_text_console_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_writer: self-checking testbench for the text console writer
// a short table of directed beats runs at reset colors, then phases of random
// puts and reads with new colors and idle patterns follow, long enough for
// the screen to scroll; every result beat is checked against the view typed
// in the table or against a shadow console model of the cell buffer and cursor
// ----------------------------------------------------------------------------
module tb_text_console_writer;
    import tcw_pkg::*;

    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int RANDOM_ITEMS  = 1950;
    localparam int PHASE_ITEMS   = 300;
    localparam int READ_PCT      = 3;
    localparam int DRAIN_CYCLES  = 16;
    localparam int DIRECTED_ROWS = 19;
    localparam bit TYPED         = 1'b1;
    localparam bit PREDICTED     = 1'b0;

    typedef struct packed {
        logic [CELL_W-1:0] cell_data;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } console_view_t;

    typedef struct packed {
        logic              cmd;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  rr;
        logic [COL_W-1:0]  rc;
        logic              typed;
        logic [CELL_W-1:0] cell_data;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } console_stim_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_we;
    logic               cfg_index;
    logic [COLOR_W-1:0] cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic               s_cmd;
    logic [CHAR_W-1:0]  s_char_code;
    logic [ROW_W-1:0]   s_read_row;
    logic [COL_W-1:0]   s_read_col;
    logic               m_valid;
    logic               m_ready;
    logic [CELL_W-1:0]  m_cell_data;
    logic [ROW_W-1:0]   m_cursor_row;
    logic [COL_W-1:0]   m_cursor_col;

    // shadow console
    logic [CELL_W-1:0]  shadow_cells [CELLS];
    int                 shadow_row;
    int                 shadow_col;
    logic [COLOR_W-1:0] shadow_bg;
    logic [COLOR_W-1:0] shadow_fg;

    console_view_t      pending_views [$];
    console_view_t      oldest_view;
    console_stim_t      directed_rows [DIRECTED_ROWS];
    int                 error_count;
    int                 cycle_count;
    int                 sender_idle_pct;
    int                 recv_stall_pct;

    text_console_writer u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_char_code  (s_char_code),
        .s_read_row   (s_read_row),
        .s_read_col   (s_read_col),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cell_data  (m_cell_data),
        .m_cursor_row (m_cursor_row),
        .m_cursor_col (m_cursor_col)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic console_view_t console_predict(input logic cmd,
                                                      input logic [CHAR_W-1:0] ch,
                                                      input logic [ROW_W-1:0] rr,
                                                      input logic [COL_W-1:0] rc);
        console_view_t          v;
        logic [2*COLOR_W-1:0]   attr;
        int                     i;
        v.cell_data = '0;
        attr        = {shadow_bg, shadow_fg};
        if (cmd == CMD_PUT) begin
            shadow_cells[shadow_row * COLUMNS + shadow_col] = {attr, ch};
            shadow_col++;
            if (shadow_col >= COLUMNS) begin
                shadow_col = 0;
                shadow_row++;
                if (shadow_row >= ROWS) begin
                    // rows move up keeping the character, taking current colors
                    for (i = 0; i < CELLS - COLUMNS; i++) begin
                        shadow_cells[i] = {attr, shadow_cells[i + COLUMNS][CHAR_W-1:0]};
                    end
                    for (i = CELLS - COLUMNS; i < CELLS; i++) begin
                        shadow_cells[i] = '0;
                    end
                    shadow_row = ROWS - 1;
                end
            end
        end else if (rr < ROWS && rc < COLUMNS) begin
            v.cell_data = shadow_cells[rr * COLUMNS + rc];
        end
        v.row = shadow_row[ROW_W-1:0];
        v.col = shadow_col[COL_W-1:0];
        return v;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    task automatic send_beat(input logic cmd, input logic [CHAR_W-1:0] ch,
                             input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc,
                             input logic typed, input console_view_t typed_view);
        console_view_t predicted;
        if ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_char_code <= ch;
        s_read_row  <= rr;
        s_read_col  <= rc;
        do @(posedge aclk); while (!s_ready);
        predicted = console_predict(cmd, ch, rr, rc);
        pending_views.push_back(typed ? typed_view : predicted);
    endtask

    task automatic send_random;
        logic              cmd;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  rr;
        logic [COL_W-1:0]  rc;
        int                pick;
        cmd  = ($urandom_range(99) < READ_PCT) ? CMD_READ : CMD_PUT;
        ch   = CHAR_W'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 60) begin
            rr = ROW_W'($urandom_range(ROWS - 1));
            rc = COL_W'($urandom_range(COLUMNS - 1));
        end else if (pick < 80) begin
            // cursor row, where the freshest cells are
            rr = shadow_row[ROW_W-1:0];
            rc = COL_W'($urandom_range(COLUMNS - 1));
        end else begin
            rr = ROW_W'($urandom);
            rc = COL_W'($urandom);
        end
        send_beat(cmd, ch, rr, rc, PREDICTED, '0);
    endtask

    task automatic wait_drained;
        s_valid <= 1'b0;
        while (pending_views.size() != 0) @(posedge aclk);
    endtask

    task automatic write_colors(input logic [COLOR_W-1:0] bg, input logic [COLOR_W-1:0] fg);
        cfg_we    <= 1'b1;
        cfg_index <= REG_BACKGROUND;
        cfg_data  <= bg;
        @(posedge aclk);
        cfg_index <= REG_FOREGROUND;
        cfg_data  <= fg;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        shadow_bg = bg;
        shadow_fg = fg;
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_views.size() == 0) begin
                report_mismatch("beat with nothing pending, cell", 32'(m_cell_data), 0);
            end else begin
                oldest_view = pending_views.pop_front();
                if (m_cell_data !== oldest_view.cell_data)
                    report_mismatch("cell_data", 32'(m_cell_data),
                                    32'(oldest_view.cell_data));
                if (m_cursor_row !== oldest_view.row)
                    report_mismatch("cursor_row", 32'(m_cursor_row),
                                    32'(oldest_view.row));
                if (m_cursor_col !== oldest_view.col)
                    report_mismatch("cursor_col", 32'(m_cursor_col),
                                    32'(oldest_view.col));
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        int                 p;
        int                 sent;
        logic [COLOR_W-1:0] bg;
        logic [COLOR_W-1:0] fg;
        aresetn         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_BACKGROUND;
        cfg_data        = '0;
        s_valid         = 1'b0;
        s_cmd           = CMD_PUT;
        s_char_code     = '0;
        s_read_row      = '0;
        s_read_col      = '0;
        error_count     = 0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        shadow_row      = 0;
        shadow_col      = 0;
        shadow_bg       = BG_RESET;
        shadow_fg       = FG_RESET;
        foreach (shadow_cells[i]) shadow_cells[i] = '0;

        directed_rows = '{
            '{CMD_READ, 8'h00, 5'd0,  7'd0,   TYPED,     16'h0000, 5'd0, 7'd0},
            '{CMD_READ, 8'hFF, 5'd31, 7'd127, TYPED,     16'h0000, 5'd0, 7'd0},
            '{CMD_READ, 8'h00, 5'd24, 7'd79,  TYPED,     16'h0000, 5'd0, 7'd0},
            '{CMD_READ, 8'h00, 5'd25, 7'd0,   TYPED,     16'h0000, 5'd0, 7'd0},
            '{CMD_READ, 8'h00, 5'd0,  7'd80,  TYPED,     16'h0000, 5'd0, 7'd0},
            '{CMD_PUT,  8'h00, 5'd0,  7'd0,   TYPED,     16'h0000, 5'd0, 7'd1},
            '{CMD_PUT,  8'hFF, 5'd31, 7'd127, TYPED,     16'h0000, 5'd0, 7'd2},
            '{CMD_PUT,  8'h0A, 5'd0,  7'd0,   TYPED,     16'h0000, 5'd0, 7'd3},
            '{CMD_PUT,  8'h0D, 5'd0,  7'd0,   TYPED,     16'h0000, 5'd0, 7'd4},
            '{CMD_READ, 8'h00, 5'd0,  7'd0,   TYPED,     16'h0F00, 5'd0, 7'd4},
            '{CMD_READ, 8'h00, 5'd0,  7'd1,   TYPED,     16'h0FFF, 5'd0, 7'd4},
            '{CMD_READ, 8'h00, 5'd0,  7'd2,   TYPED,     16'h0F0A, 5'd0, 7'd4},
            '{CMD_READ, 8'h00, 5'd0,  7'd4,   TYPED,     16'h0000, 5'd0, 7'd4},
            '{CMD_PUT,  8'h55, 5'd10, 7'd42,  PREDICTED, 16'h0000, 5'd0, 7'd0},
            '{CMD_PUT,  8'hAA, 5'd21, 7'd85,  PREDICTED, 16'h0000, 5'd0, 7'd0},
            '{CMD_READ, 8'h00, 5'd0,  7'd4,   PREDICTED, 16'h0000, 5'd0, 7'd0},
            '{CMD_READ, 8'h00, 5'd0,  7'd5,   PREDICTED, 16'h0000, 5'd0, 7'd0},
            '{CMD_READ, 8'h00, 5'd24, 7'd0,   TYPED,     16'h0000, 5'd0, 7'd6},
            '{CMD_READ, 8'h00, 5'd1,  7'd0,   TYPED,     16'h0000, 5'd0, 7'd6}
        };

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_beat(directed_rows[i].cmd, directed_rows[i].ch, directed_rows[i].rr,
                      directed_rows[i].rc, directed_rows[i].typed,
                      {directed_rows[i].cell_data, directed_rows[i].row,
                       directed_rows[i].col});
        end
        wait_drained;

        p    = 0;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case (p % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin sender_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            case (p)
                0: begin bg = 4'hF; fg = 4'h0; end
                1: begin bg = 4'h0; fg = 4'hF; end
                2: begin bg = 4'hF; fg = 4'hF; end
                3: begin bg = 4'h0; fg = 4'h0; end
                default: begin bg = COLOR_W'($urandom); fg = COLOR_W'($urandom); end
            endcase
            write_colors(bg, fg);
            repeat (PHASE_ITEMS) begin
                send_random;
                sent++;
            end
            wait_drained;
            p++;
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### sim.f
src/tcw_pkg.sv
src/tcw_ram.sv
src/text_console_writer.sv
tb/tb_text_console_writer.sv
